### rtl/core/iocnt_pkg.sv
// iocnt_pkg: shared constants, payload structs, command/status structs and state
// encoding for the interval overlap counter. No dependencies.
package iocnt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int COORD_BITS    = 32;
   localparam int CHROM_BITS    = 8;
   localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int COUNT_W       = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [CHROM_BITS-1:0] chrom_id;
      logic [COORD_BITS-1:0] interval_start;
      logic [COORD_BITS-1:0] interval_end;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] overlap_count;
      logic               table_overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHROM_BITS-1:0] chrom;
      logic [COORD_BITS-1:0] start;
      logic [COORD_BITS-1:0] stop;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic load_wr;
      logic scan_init;
      logic scan_rd;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic              table_empty;
      logic              scan_last;
      logic [FILL_W-1:0] fill_level;
   } sts_type;

endpackage

### rtl/core/iocnt_ctrl.sv
// iocnt_ctrl: request decode, scan sequencing and response handshake.
// Depends on iocnt_pkg.
module iocnt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  iocnt_pkg::sts_type        sts,
   output iocnt_pkg::cmd_type        cmd
);
   import iocnt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == FUNC_QUERY)) begin
               state_in = sts.table_empty ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  FUNC_CLEAR: cmd.clear     = 1'b1;
                  FUNC_LOAD:  cmd.load_wr   = 1'b1;
                  FUNC_QUERY: cmd.scan_init = 1'b1;
                  default:    cmd = '0;
               endcase
            end
         end
         ST_SCAN:   cmd.scan_rd     = 1'b1;
         ST_DRAIN:  cmd             = '0;
         ST_FINISH: cmd.result_load = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/iocnt_dpath.sv
// iocnt_dpath: interval table memory, fill level, overflow flag, scan address,
// overlap compare and count accumulator, response payload register. Depends on iocnt_pkg.
module iocnt_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  iocnt_pkg::req_payload_type    req_payload,
   input  iocnt_pkg::cmd_type            cmd,
   output iocnt_pkg::sts_type            sts,
   output iocnt_pkg::rsp_payload_type    rsp_payload
);
   import iocnt_pkg::*;

   entry_type             mem [TABLE_ENTRIES];
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  ovf_ff, ovf_in;
   logic [ADDR_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                  rd_vld_ff, rd_vld_in;
   entry_type             rd_data_ff;
   entry_type             query_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   rsp_payload_type       rsp_ff;
   logic                  table_full;
   logic                  hit;

   assign table_full = (fill_ff == FILL_W'(TABLE_ENTRIES));

   assign sts.table_empty = (fill_ff == '0);
   assign sts.scan_last   = ((FILL_W'(scan_addr_ff) + FILL_W'(1)) == fill_ff);
   assign sts.fill_level  = fill_ff;

   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (cmd.clear) begin
         fill_in = '0;
         ovf_in  = 1'b0;
      end else if (cmd.load_wr) begin
         if (table_full) begin
            ovf_in = 1'b1;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_init) begin
         scan_addr_in = '0;
      end else if (cmd.scan_rd) begin
         scan_addr_in = scan_addr_ff + ADDR_W'(1);
      end
   end

   assign rd_vld_in = cmd.scan_rd;

   // half-open overlap on a matching chromosome, book-ended ranges miss
   assign hit = rd_vld_ff
             && (rd_data_ff.chrom == query_ff.chrom)
             && (rd_data_ff.start < query_ff.stop)
             && (query_ff.start < rd_data_ff.stop);

   always_comb begin
      count_in = count_ff;
      if (cmd.scan_init) begin
         count_in = '0;
      end else if (hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_addr_ff <= '0;
         count_ff     <= '0;
      end else begin
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rd_vld_ff    <= rd_vld_in;
         scan_addr_ff <= scan_addr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && !table_full) begin
         mem[fill_ff[ADDR_W-1:0]] <= '{chrom: req_payload.chrom_id,
                                       start: req_payload.interval_start,
                                       stop:  req_payload.interval_end};
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         query_ff <= '{chrom: req_payload.chrom_id,
                       start: req_payload.interval_start,
                       stop:  req_payload.interval_end};
      end
      if (cmd.result_load) begin
         rsp_ff <= '{overlap_count: count_ff, table_overflowed: ovf_ff};
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/interval_overlap_counter_unit.sv
// interval_overlap_counter_unit: top level, controller plus datapath.
// Depends on iocnt_pkg, iocnt_ctrl, iocnt_dpath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_payload (func, chrom_id, start, end)
//   rsp       out         rsp_valid/rsp_ready    rsp_payload (overlap_count, overflowed)
//
// clear and load transactions produce no response.
// a query is accepted, then reads each stored entry in turn from the single table read
// port, waits out the read latency in the drain state and posts the result in the finish state.
// a query on an empty table skips the scan and goes straight to the finish state.
// reset is synchronous; the table needs no clearing pass, the fill level marks valid rows.
// a stalled response holds in its output register while new loads and clears are taken;
// a later query waits in its post cycle until that response is taken.
module interval_overlap_counter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  iocnt_pkg::req_payload_type    req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output iocnt_pkg::rsp_payload_type    rsp_payload
);
   import iocnt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   iocnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_payload.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iocnt_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

   // at most one table operation per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load_wr, cmd.scan_init, cmd.scan_rd, cmd.result_load}))
      else $error("conflicting datapath commands");

   // a result never overwrites one that has not been taken
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over pending response");

   // fill level stays within the table
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      sts.fill_level <= FILL_W'(TABLE_ENTRIES))
      else $error("fill level beyond table depth");

   // a query result is not posted straight after acceptance unless the table was empty
   a_rsp_after_query: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_init |=> !cmd.result_load || $past(sts.table_empty))
      else $error("result posted before scan");

endmodule
